// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/amic_pkg.sv =====
// ---------------------------------------------------------------------------
// amic_pkg
// shared types, constants and arithmetic helpers of the affine inverse core
// ---------------------------------------------------------------------------
package amic_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_BITS   = 17;
    localparam int ADDR_BITS  = 5;
    localparam int MEM_DEPTH  = 32;
    localparam int NUM_MTX    = 12;
    localparam int TDATA_BITS = 104;
    localparam int PC_BITS    = 6;
    localparam int QUOT_BITS  = 2 * FRAC_BITS + 2;

    localparam logic [WORD_BITS-1:0] FX_ONE = WORD_BITS'(1) << FRAC_BITS;

    // scratch addresses
    localparam logic [ADDR_BITS-1:0] A_COF  = 5'd12;
    localparam logic [ADDR_BITS-1:0] A_IDET = 5'd23;
    localparam logic [ADDR_BITS-1:0] A_TRN  = 5'd24;

    // program counter marks
    localparam logic [PC_BITS-1:0] PC_DET_END   = 6'd22;
    localparam logic [PC_BITS-1:0] PC_INV_START = 6'd23;
    localparam logic [PC_BITS-1:0] PC_LAST      = 6'd40;

    // accumulate kinds
    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_SUB  = 2'd1;
    localparam logic [1:0] K_ADD  = 2'd2;

    typedef struct packed {
        logic                 trigger;
        logic [1:0]           col;
        logic [WORD_BITS-1:0] r2;
        logic [WORD_BITS-1:0] r1;
        logic [WORD_BITS-1:0] r0;
    } item_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] src_a;
        logic [ADDR_BITS-1:0] src_b;
        logic [ADDR_BITS-1:0] dst;
        logic                 wr;
        logic                 neg;
    } uop_t;

    function automatic uop_t mk(input logic [1:0] kind, input int a, input int b,
                                input logic wr, input logic neg, input int dst);
        uop_t u;
        u.kind  = kind;
        u.src_a = ADDR_BITS'(a);
        u.src_b = ADDR_BITS'(b);
        u.dst   = ADDR_BITS'(dst);
        u.wr    = wr;
        u.neg   = neg;
        return u;
    endfunction

    // micro-program: cofactors, determinant, scaled inverse, translation
    function automatic uop_t uop_at(input logic [PC_BITS-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(K_LOAD, 4, 8, 1'b0, 1'b0, 0);
            6'd1:  u = mk(K_SUB,  5, 7, 1'b1, 1'b0, 12);
            6'd2:  u = mk(K_LOAD, 7, 2, 1'b0, 1'b0, 0);
            6'd3:  u = mk(K_SUB,  8, 1, 1'b1, 1'b0, 13);
            6'd4:  u = mk(K_LOAD, 1, 5, 1'b0, 1'b0, 0);
            6'd5:  u = mk(K_SUB,  2, 4, 1'b1, 1'b0, 14);
            6'd6:  u = mk(K_LOAD, 5, 6, 1'b0, 1'b0, 0);
            6'd7:  u = mk(K_SUB,  3, 8, 1'b1, 1'b0, 15);
            6'd8:  u = mk(K_LOAD, 8, 0, 1'b0, 1'b0, 0);
            6'd9:  u = mk(K_SUB,  6, 2, 1'b1, 1'b0, 16);
            6'd10: u = mk(K_LOAD, 2, 3, 1'b0, 1'b0, 0);
            6'd11: u = mk(K_SUB,  0, 5, 1'b1, 1'b0, 17);
            6'd12: u = mk(K_LOAD, 3, 7, 1'b0, 1'b0, 0);
            6'd13: u = mk(K_SUB,  4, 6, 1'b1, 1'b0, 18);
            6'd14: u = mk(K_LOAD, 6, 1, 1'b0, 1'b0, 0);
            6'd15: u = mk(K_SUB,  7, 0, 1'b1, 1'b0, 19);
            6'd16: u = mk(K_LOAD, 0, 4, 1'b0, 1'b0, 0);
            6'd17: u = mk(K_SUB,  1, 3, 1'b1, 1'b0, 20);
            6'd18: u = mk(K_LOAD, 1, 8, 1'b0, 1'b0, 0);
            6'd19: u = mk(K_SUB,  2, 7, 1'b1, 1'b0, 21);
            6'd20: u = mk(K_LOAD, 0, 12, 1'b0, 1'b0, 0);
            6'd21: u = mk(K_SUB,  3, 21, 1'b0, 1'b0, 0);
            6'd22: u = mk(K_ADD,  6, 14, 1'b0, 1'b0, 0);
            6'd23: u = mk(K_LOAD, 23, 12, 1'b1, 1'b0, 12);
            6'd24: u = mk(K_LOAD, 23, 13, 1'b1, 1'b0, 13);
            6'd25: u = mk(K_LOAD, 23, 14, 1'b1, 1'b0, 14);
            6'd26: u = mk(K_LOAD, 23, 15, 1'b1, 1'b0, 15);
            6'd27: u = mk(K_LOAD, 23, 16, 1'b1, 1'b0, 16);
            6'd28: u = mk(K_LOAD, 23, 17, 1'b1, 1'b0, 17);
            6'd29: u = mk(K_LOAD, 23, 18, 1'b1, 1'b0, 18);
            6'd30: u = mk(K_LOAD, 23, 19, 1'b1, 1'b0, 19);
            6'd31: u = mk(K_LOAD, 23, 20, 1'b1, 1'b0, 20);
            6'd32: u = mk(K_LOAD, 9, 12, 1'b0, 1'b0, 0);
            6'd33: u = mk(K_ADD,  10, 15, 1'b0, 1'b0, 0);
            6'd34: u = mk(K_ADD,  11, 18, 1'b1, 1'b1, 24);
            6'd35: u = mk(K_LOAD, 9, 13, 1'b0, 1'b0, 0);
            6'd36: u = mk(K_ADD,  10, 16, 1'b0, 1'b0, 0);
            6'd37: u = mk(K_ADD,  11, 19, 1'b1, 1'b1, 25);
            6'd38: u = mk(K_LOAD, 9, 14, 1'b0, 1'b0, 0);
            6'd39: u = mk(K_ADD,  10, 17, 1'b0, 1'b0, 0);
            6'd40: u = mk(K_ADD,  11, 20, 1'b1, 1'b1, 26);
            default: u = mk(K_LOAD, 0, 0, 1'b0, 1'b0, 0);
        endcase
        return u;
    endfunction

    // clamp a grown sum back to the word
    function automatic logic [WORD_BITS-1:0] sat_sum(input logic [WORD_BITS:0] s);
        logic [WORD_BITS-1:0] r;
        if (s[WORD_BITS] != s[WORD_BITS-1])
            r = s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        else
            r = s[WORD_BITS-1:0];
        return r;
    endfunction

    // round half away from zero, drop fraction bits, saturate
    function automatic logic [WORD_BITS-1:0] fx_round(input logic [2*WORD_BITS-1:0] p);
        logic                       neg;
        logic [2*WORD_BITS-1:0]     mag;
        logic [2*WORD_BITS-1:0]     nm;
        logic [2*WORD_BITS-FRAC_BITS-1:0] r;
        logic [2*WORD_BITS-FRAC_BITS-1:0] lim;
        neg = p[2*WORD_BITS-1];
        mag = neg ? (~p + 1'b1) : p;
        nm  = mag + ((2*WORD_BITS)'(1) << (FRAC_BITS - 1));
        r   = nm[2*WORD_BITS-1:FRAC_BITS];
        lim = ((2*WORD_BITS-FRAC_BITS)'(1) << (WORD_BITS - 1))
              - (neg ? (2*WORD_BITS-FRAC_BITS)'(0) : (2*WORD_BITS-FRAC_BITS)'(1));
        if (r > lim)
            r = lim;
        return neg ? (~r[WORD_BITS-1:0] + 1'b1) : r[WORD_BITS-1:0];
    endfunction

    // scratch address of an output column row
    function automatic logic [ADDR_BITS-1:0] out_addr(input logic [1:0] col,
                                                      input logic [1:0] row);
        logic [ADDR_BITS-1:0] a;
        if (col == 2'd3)
            a = A_TRN + ADDR_BITS'(row);
        else
            a = A_COF + ADDR_BITS'(col) * ADDR_BITS'(3) + ADDR_BITS'(row);
        return a;
    endfunction

endpackage

// ===== sv/amic_front.sv =====
// ---------------------------------------------------------------------------
// amic_front
// input register stage, unpacks and tags each column transaction
// ---------------------------------------------------------------------------
module amic_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [amic_pkg::TDATA_BITS-1:0]  s_tdata,
    output logic                             push_valid,
    input  logic                             push_ready,
    output amic_pkg::item_t                  push_item
);

    logic            hold_valid_reg;
    amic_pkg::item_t hold_item_reg;
    amic_pkg::item_t in_item;

    always_comb
    begin
        in_item.col     = s_tdata[1:0];
        in_item.r0      = s_tdata[33:2];
        in_item.r1      = s_tdata[65:34];
        in_item.r2      = s_tdata[97:66];
        in_item.trigger = (s_tdata[1:0] == 2'd3);
    end

    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            hold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            hold_item_reg <= in_item;
        end
    end

endmodule

// ===== sv/amic_fifo.sv =====
// ---------------------------------------------------------------------------
// amic_fifo
// two-entry queue of column transactions between front and back
// ---------------------------------------------------------------------------
module amic_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  amic_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output amic_pkg::item_t pop_item
);

    amic_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/amic_div.sv =====
// ---------------------------------------------------------------------------
// amic_div
// restoring divider, one quotient bit per cycle, for the reciprocal
// ---------------------------------------------------------------------------
module amic_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [amic_pkg::WORD_BITS-1:0]  divisor,
    output logic                            done,
    output logic [amic_pkg::QUOT_BITS-1:0]  quotient
);

    localparam int QB = amic_pkg::QUOT_BITS;
    localparam int WB = amic_pkg::WORD_BITS;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [QB-1:0] num_reg;
    logic [QB-1:0] quot_reg;
    logic [WB-1:0] rem_reg;
    logic [WB-1:0] den_reg;
    logic [WB:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, num_reg[QB-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QB - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= (QB'(1) << (2 * amic_pkg::FRAC_BITS)) + QB'(divisor >> 1);
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[QB-2:0], 1'b0};
            quot_reg <= {quot_reg[QB-2:0], fits};
            rem_reg  <= fits ? WB'(trial - {1'b0, den_reg}) : trial[WB-1:0];
        end
    end

endmodule

// ===== sv/amic_back.sv =====
// ---------------------------------------------------------------------------
// amic_back
// matrix store, micro-coded multiply-accumulate sequencer and result output
// ---------------------------------------------------------------------------
module amic_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [amic_pkg::THR_BITS-1:0]     thr,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  amic_pkg::item_t                   pop_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        out_col,
    output logic [amic_pkg::WORD_BITS-1:0]    out_r0,
    output logic [amic_pkg::WORD_BITS-1:0]    out_r1,
    output logic [amic_pkg::WORD_BITS-1:0]    out_r2,
    output logic                              out_sing,
    output logic                              out_last
);

    localparam int WB = amic_pkg::WORD_BITS;
    localparam int AB = amic_pkg::ADDR_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LD    = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_ORD0  = 4'd7;
    localparam logic [3:0] S_ORD1  = 4'd8;
    localparam logic [3:0] S_ORD2  = 4'd9;
    localparam logic [3:0] S_OWAIT = 4'd10;

    logic [WB-1:0] mem [amic_pkg::MEM_DEPTH];

    logic [3:0]                       state_reg, state_next;
    logic [amic_pkg::PC_BITS-1:0]     pc_reg;
    logic [1:0]                       row_reg;
    logic [1:0]                       ocol_reg;
    amic_pkg::item_t                  ld_reg;
    logic [WB-1:0]                    acc_reg;
    logic signed [2*WB-1:0]           prod_reg;
    logic                             sing_reg;
    logic [amic_pkg::NUM_MTX-1:0]     mvalid_reg;
    logic                             ok_a_reg, ok_b_reg;
    logic [WB-1:0]                    rd_a_reg, rd_b_reg;
    logic                             ovalid_reg;
    logic [WB-1:0]                    or0_reg, or1_reg, or2_reg;

    amic_pkg::uop_t    uop;
    logic [AB-1:0]     raddr_a, raddr_b, waddr;
    logic [WB-1:0]     wdata;
    logic              we;
    logic [WB-1:0]     rd_a, rd_b;
    logic [WB-1:0]     rnd;
    logic [WB-1:0]     acc_next;
    logic [WB-1:0]     acc_neg;
    logic [WB-1:0]     det_mag;
    logic              is_sing;
    logic              div_start;
    logic              div_done;
    logic [amic_pkg::QUOT_BITS-1:0] quot;
    logic [amic_pkg::QUOT_BITS-1:0] qlim;
    logic [amic_pkg::QUOT_BITS-1:0] qsat;
    logic [WB-1:0]     idet;
    logic [WB-1:0]     id0, id1, id2;

    assign uop  = amic_pkg::uop_at(pc_reg);
    assign rd_a = ok_a_reg ? rd_a_reg : '0;
    assign rd_b = ok_b_reg ? rd_b_reg : '0;
    assign rnd  = amic_pkg::fx_round(prod_reg);

    always_comb
    begin
        case (uop.kind)
            amic_pkg::K_SUB:
                acc_next = amic_pkg::sat_sum({acc_reg[WB-1], acc_reg} - {rnd[WB-1], rnd});
            amic_pkg::K_ADD:
                acc_next = amic_pkg::sat_sum({acc_reg[WB-1], acc_reg} + {rnd[WB-1], rnd});
            default:
                acc_next = rnd;
        endcase
        acc_neg = amic_pkg::sat_sum((WB+1)'(0) - {acc_next[WB-1], acc_next});
    end

    // determinant check and reciprocal scaling
    assign det_mag = acc_reg[WB-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign is_sing = (acc_reg == '0) || (det_mag < WB'(thr));
    assign qlim    = (amic_pkg::QUOT_BITS'(1) << (WB - 1))
                     - (acc_reg[WB-1] ? amic_pkg::QUOT_BITS'(0) : amic_pkg::QUOT_BITS'(1));
    assign qsat    = (quot > qlim) ? qlim : quot;
    assign idet    = acc_reg[WB-1] ? (~qsat[WB-1:0] + 1'b1) : qsat[WB-1:0];

    // identity column
    assign id0 = (ocol_reg == 2'd0) ? amic_pkg::FX_ONE : '0;
    assign id1 = (ocol_reg == 2'd1) ? amic_pkg::FX_ONE : '0;
    assign id2 = (ocol_reg == 2'd2) ? amic_pkg::FX_ONE : '0;

    amic_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (det_mag),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        raddr_a    = uop.src_a;
        raddr_b    = uop.src_b;
        we         = 1'b0;
        waddr      = uop.dst;
        wdata      = uop.neg ? acc_neg : acc_next;
        div_start  = 1'b0;
        pop_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                    state_next = S_LD;
            end
            S_LD:
            begin
                we    = 1'b1;
                waddr = AB'(ld_reg.col) * AB'(3) + AB'(row_reg);
                case (row_reg)
                    2'd0:    wdata = ld_reg.r0;
                    2'd1:    wdata = ld_reg.r1;
                    default: wdata = ld_reg.r2;
                endcase
                if (row_reg == 2'd2)
                    state_next = ld_reg.trigger ? S_RD : S_IDLE;
            end
            S_RD:
                state_next = S_MUL;
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                we = uop.wr;
                if (pc_reg == amic_pkg::PC_DET_END)
                    state_next = S_CHK;
                else if (pc_reg == amic_pkg::PC_LAST)
                    state_next = S_ORD0;
                else
                    state_next = S_RD;
            end
            S_CHK:
            begin
                if (is_sing)
                    state_next = S_ORD0;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    we         = 1'b1;
                    waddr      = amic_pkg::A_IDET;
                    wdata      = idet;
                    state_next = S_RD;
                end
            end
            S_ORD0:
            begin
                raddr_a    = amic_pkg::out_addr(ocol_reg, 2'd0);
                raddr_b    = amic_pkg::out_addr(ocol_reg, 2'd1);
                state_next = S_ORD1;
            end
            S_ORD1:
            begin
                raddr_a    = amic_pkg::out_addr(ocol_reg, 2'd2);
                state_next = S_ORD2;
            end
            S_ORD2:
                state_next = S_OWAIT;
            S_OWAIT:
            begin
                if (out_ready)
                    state_next = (ocol_reg == 2'd3) ? S_IDLE : S_ORD0;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            row_reg    <= 2'd0;
            ocol_reg   <= 2'd0;
            sing_reg   <= 1'b0;
            mvalid_reg <= '0;
            ok_a_reg   <= 1'b0;
            ok_b_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_a_reg  <= (raddr_a >= AB'(amic_pkg::NUM_MTX)) || mvalid_reg[raddr_a[3:0]];
            ok_b_reg  <= (raddr_b >= AB'(amic_pkg::NUM_MTX)) || mvalid_reg[raddr_b[3:0]];
            if (we && (waddr < AB'(amic_pkg::NUM_MTX)))
                mvalid_reg[waddr[3:0]] <= 1'b1;
            if (state_reg == S_IDLE)
                row_reg <= 2'd0;
            else if (state_reg == S_LD)
                row_reg <= row_reg + 2'd1;
            if (state_reg == S_LD)
                pc_reg <= '0;
            else if (state_reg == S_ACC)
                pc_reg <= pc_reg + 1'b1;
            else if (state_reg == S_DIV)
                pc_reg <= amic_pkg::PC_INV_START;
            if (state_reg == S_LD)
            begin
                ocol_reg <= 2'd0;
                sing_reg <= 1'b0;
            end
            if (state_reg == S_CHK)
                sing_reg <= is_sing;
            if (state_reg == S_ORD2)
                ovalid_reg <= 1'b1;
            if (state_reg == S_OWAIT && out_ready)
            begin
                ovalid_reg <= 1'b0;
                ocol_reg   <= ocol_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
        if (state_reg == S_IDLE && pop_valid)
            ld_reg <= pop_item;
        if (state_reg == S_MUL)
            prod_reg <= $signed(rd_a) * $signed(rd_b);
        if (state_reg == S_ACC)
            acc_reg <= acc_next;
        if (state_reg == S_ORD1)
        begin
            or0_reg <= sing_reg ? id0 : rd_a;
            or1_reg <= sing_reg ? id1 : rd_b;
        end
        if (state_reg == S_ORD2)
            or2_reg <= sing_reg ? id2 : rd_a;
    end

    assign out_valid = ovalid_reg;
    assign out_col   = ocol_reg;
    assign out_r0    = or0_reg;
    assign out_r1    = or1_reg;
    assign out_r2    = or2_reg;
    assign out_sing  = sing_reg;
    assign out_last  = (ocol_reg == 2'd3);

endmodule

// ===== sv/affine_matrix_inverse_core.sv =====
// ---------------------------------------------------------------------------
// affine_matrix_inverse_core
// inverse of a column-major 4x4 affine matrix in signed Q16.16
// ---------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                        tuser     tlast
// s_axis    in   column_index, row0, row1, row2 values     -         -
// m_axis    out  out_column, inv_row0, inv_row1, inv_row2  singular  last_column
// cfg_wr    in   singular_threshold (17 bits)              -         -
//
// a column 0..2 transaction is written row by row into the back-end store; a
// translation column also runs 23 micro-ops (read, multiply, accumulate) on
// one shared 32x32 multiplier for cofactors and determinant, a check and,
// when not singular, the bit-serial reciprocal divider and 18 more micro-ops,
// then 4 results, each held while m_axis_tready is low. a two-entry queue
// lets the input side keep accepting while the back end computes or waits
// on m_axis_tready.
// reset is asynchronous; the matrix store reads as zero until written.
// ---------------------------------------------------------------------------
module affine_matrix_inverse_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // column_index, row0_value, row1_value, row2_value, zero pad
    input  logic [amic_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_column, inv_row0, inv_row1, inv_row2, zero pad
    output logic [amic_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    // singular
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             cfg_wr_en,
    input  logic [amic_pkg::THR_BITS-1:0]    cfg_wr_data
);

    logic                             thr_reg;
    logic [amic_pkg::THR_BITS-1:0]    thr_val_reg;
    logic                             push_valid, push_ready;
    amic_pkg::item_t                  push_item;
    logic                             pop_valid, pop_ready;
    amic_pkg::item_t                  pop_item;
    logic [1:0]                       out_col;
    logic [amic_pkg::WORD_BITS-1:0]   out_r0, out_r1, out_r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_val_reg <= amic_pkg::THR_BITS'(1);
            thr_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            thr_val_reg <= cfg_wr_data;
            thr_reg     <= 1'b1;
        end
    end

    amic_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    amic_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    amic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg ? thr_val_reg : thr_val_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_col   (out_col),
        .out_r0    (out_r0),
        .out_r1    (out_r1),
        .out_r2    (out_r2),
        .out_sing  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_r2, out_r1, out_r0, out_col};

endmodule

// ===== sv/amic_checker.sv =====
// ---------------------------------------------------------------------------
// amic_checker
// port-level checks on the result stream of the affine inverse core
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module amic_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [amic_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [amic_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast,
    input logic                             cfg_wr_en,
    input logic [amic_pkg::THR_BITS-1:0]    cfg_wr_data
);

    `AST_IMPL(a_last_is_col3, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[1:0] == 2'd3))
    `AST_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `AST_IMPL(a_sing_ident, m_axis_tvalid && m_axis_tuser && m_axis_tdata[1:0] == 2'd0, m_axis_tdata[33:2] == 32'h00010000 && m_axis_tdata[97:34] == 64'd0)
    `AST_NEXT(a_col_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1)

endmodule

bind affine_matrix_inverse_core amic_checker u_amic_checker (.*);
